/* hw/rtl/pmsm_pkg.sv */
// Shared constants, types and arithmetic helpers for the PMSM model step core.
package pmsm_pkg;

    // Fixed-point layout
    localparam int SINE_TABLE_BITS = 10;
    localparam int FRAC_BITS       = 16;
    localparam int POS_FRAC        = 24;
    localparam int QSIZE_BITS      = SINE_TABLE_BITS - 2;
    localparam int QSIZE           = 1 << QSIZE_BITS;
    localparam int QS_W            = FRAC_BITS + 1;
    localparam int SINE_W          = FRAC_BITS + 2;

    // Shared multiplier and internal widths
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int TMP_W     = PROD_W - FRAC_BITS;
    localparam int DOT_W     = TMP_W + 2;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int TRAP_SHIFT = 33;
    localparam int POS_SHIFT  = FRAC_BITS + TRAP_SHIFT - POS_FRAC;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [29:0]     TURNS_PER_RAD_Q32 = 30'd683565276;
    localparam logic [31:0]     THIRD_TURN = 32'h5555_5555;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RES       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_L     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_J     = 3'd6;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TMP_W-1:0]  tmp_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [QSIZE-1:0][QS_W-1:0] qsine_tab_t;

    typedef struct packed {
        logic signed [31:0] volt_a;
        logic signed [31:0] volt_b;
        logic signed [31:0] volt_c;
        logic signed [31:0] load_torque;
        logic signed [31:0] forced_speed;
    } item_t;

    typedef struct packed {
        logic signed [31:0] motor_torque;
        logic signed [31:0] current_a;
        logic signed [31:0] current_b;
        logic signed [31:0] current_c;
        logic signed [31:0] rotor_speed;
        logic signed [31:0] rotor_acceleration;
        logic signed [47:0] rotor_position;
    } result_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic       en;
        mul_op_t    a;
        mul_op_t    b;
    } mul_req_t;

    // Unsigned long division by shift and subtract, used only to build the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem  = {rem[62:0], num[i]};
            q[i] = 1'b0;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        udiv64 = q;
    endfunction

    // Quarter-wave sine sample in Q.F, Taylor series to x^15 in Q30
    function automatic logic [QS_W-1:0] qsine_val(input int unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x = (longint'(r) * HALF_PI_Q30) >> QSIZE_BITS;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        if (sum < 0)
            sum = 0;
        qsine_val = QS_W'((sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t t;
        for (int r = 0; r < QSIZE; r++)
        begin
            t[r] = qsine_val(r);
        end
        build_qsine = t;
    endfunction

    localparam qsine_tab_t       QSINE_TAB = build_qsine();
    localparam logic [QS_W-1:0]  QSINE_TOP = qsine_val(QSIZE);

    // Sine of a turn fraction from the quarter-wave table
    function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [31:0] angle);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [1:0]                 quad;
        logic [QSIZE_BITS-1:0]      r;
        logic [QSIZE_BITS-1:0]      rn;
        logic [QS_W-1:0]            mag;
        idx  = angle[31 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[QSIZE_BITS-1:0];
        rn   = -r;
        if (!quad[0])
            mag = QSINE_TAB[r];
        else if (r == '0)
            mag = QSINE_TOP;
        else
            mag = QSINE_TAB[rn];
        if (quad[1])
            sine_lookup = -$signed({1'b0, mag});
        else
            sine_lookup = $signed({1'b0, mag});
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        if ((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]))
            sat32 = v[31:0];
        else if (v[WIDE_W-1])
            sat32 = 32'sh8000_0000;
        else
            sat32 = 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [47:0] sat48(input wide_t v);
        if ((&v[WIDE_W-1:47]) || !(|v[WIDE_W-1:47]))
            sat48 = v[47:0];
        else if (v[WIDE_W-1])
            sat48 = {1'b1, 47'b0};
        else
            sat48 = {1'b0, {47{1'b1}}};
    endfunction

    // Shift right with the magnitude rounded toward zero
    function automatic prod_t trunc_shr(input prod_t p, input int sh);
        prod_t bias;
        bias = $signed((PROD_W'(1) << sh) - PROD_W'(1));
        if (p[PROD_W-1])
            trunc_shr = (p + bias) >>> sh;
        else
            trunc_shr = p >>> sh;
    endfunction

endpackage

/* hw/rtl/pmsm_item_if.sv */
// Input channel: one motor tick request per beat.
interface pmsm_item_if;
    logic                  valid;
    logic                  ready;
    pmsm_pkg::item_t       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pmsm_result_if.sv */
// Output channel: one motor state result per beat.
interface pmsm_result_if;
    logic                  valid;
    logic                  ready;
    pmsm_pkg::result_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pmsm_motor_model_step_core.sv */
// Top level: PMSM model tick sequencer around one shared multiplier.
//
//   port       dir   handshake      beat content
//   item       in    valid/ready    volt_a, volt_b, volt_c, load_torque, forced_speed
//   result     out   valid/ready    torque, three currents, speed, acceleration, position
//   cfg_*      in    cfg_we only    register index and write data
//
// A tick runs 28 multiplies in free mode and 26 in speed-driven mode on the
// one multiplier, each an issue state (ST_MUL) and then a write-back state
// (ST_ACC); the item is accepted in ST_IDLE and the result posted in ST_DONE.
// Reset clears all motor state and loads the configuration defaults.
// A finished result waits in the output register; the next tick may run
// meanwhile and holds in its final step until the output register frees up.
module pmsm_motor_model_step_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pmsm_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [31:0]                      cfg_wdata,
    pmsm_item_if.sink                        item,
    pmsm_result_if.source                    result
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Multiply steps
    localparam logic [3:0] OP_SIN_PP = 4'd0;
    localparam logic [3:0] OP_EMF    = 4'd1;
    localparam logic [3:0] OP_BEMF   = 4'd2;
    localparam logic [3:0] OP_RDROP  = 4'd3;
    localparam logic [3:0] OP_SLOPE  = 4'd4;
    localparam logic [3:0] OP_CURR   = 4'd5;
    localparam logic [3:0] OP_DOT    = 4'd6;
    localparam logic [3:0] OP_ACCEL  = 4'd7;
    localparam logic [3:0] OP_SPEED  = 4'd8;
    localparam logic [3:0] OP_POS    = 4'd9;
    localparam logic [3:0] OP_PH_LO  = 4'd10;
    localparam logic [3:0] OP_PH_HI  = 4'd11;
    localparam logic [3:0] OP_ANG_HI = 4'd12;
    localparam logic [3:0] OP_ANG_LO = 4'd13;

    // Configuration registers
    logic        mode_reg;
    logic [31:0] ts_reg;
    logic [5:0]  pp_reg;
    logic [30:0] flux_reg;
    logic [30:0] res_reg;
    logic [30:0] invl_reg;
    logic [30:0] invj_reg;

    // Motor state
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] slope_prev_reg [3];
    logic signed [31:0] speed_reg;
    logic signed [31:0] accel_prev_reg;
    logic signed [31:0] speed_prev_reg;
    logic signed [47:0] pos_reg;
    logic [31:0]        phase_reg;

    // Working registers
    pmsm_pkg::item_t    in_reg;
    logic signed [31:0] emf_reg [3];
    pmsm_pkg::tmp_t     tmp_reg;
    pmsm_pkg::dot_t     dot_reg;
    logic signed [31:0] torque_reg;
    logic signed [31:0] acc_reg;
    logic [55:0]        x_reg;
    logic [1:0]         st_reg;
    logic [3:0]         op_reg;
    logic [1:0]         k_reg;

    // Output register
    logic               out_valid_reg;
    pmsm_pkg::result_t  out_reg;

    pmsm_pkg::mul_req_t mreq;
    pmsm_pkg::prod_t    prod;
    pmsm_pkg::tmp_t     prod_sh;
    logic [31:0]        ang_k;
    logic signed [31:0] volt_k;
    logic signed [31:0] w;
    logic signed [31:0] diff;
    pmsm_pkg::dot_t     dot_sum;
    logic [55:0]        ang_sum;
    logic               out_free;
    logic               post_res;

    pmsm_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // Per-phase selections and derived values
    always_comb
    begin
        case (k_reg)
            2'd1:
            begin
                ang_k  = phase_reg - pmsm_pkg::THIRD_TURN;
                volt_k = in_reg.volt_b;
            end
            2'd2:
            begin
                ang_k  = phase_reg + pmsm_pkg::THIRD_TURN;
                volt_k = in_reg.volt_c;
            end
            default:
            begin
                ang_k  = phase_reg;
                volt_k = in_reg.volt_a;
            end
        endcase
    end

    assign w       = mode_reg ? in_reg.forced_speed : speed_reg;
    assign prod_sh = pmsm_pkg::tmp_t'(prod >>> pmsm_pkg::FRAC_BITS);
    assign diff    = pmsm_pkg::sat32(pmsm_pkg::wide_t'(torque_reg)
                   - pmsm_pkg::wide_t'(in_reg.load_torque));
    assign dot_sum = dot_reg + pmsm_pkg::dot_t'(prod_sh);
    assign ang_sum = prod[55:0] + {tmp_reg[27:0], 28'b0};
    assign out_free = !out_valid_reg || result.ready;
    assign post_res = (st_reg == ST_DONE) && out_free;

    // Select multiplier operands for the current step
    always_comb
    begin
        mreq.en = (st_reg == ST_MUL);
        case (op_reg)
            OP_SIN_PP:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(pmsm_pkg::sine_lookup(ang_k));
                mreq.b = pmsm_pkg::mul_op_t'(pp_reg);
            end
            OP_EMF:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(tmp_reg);
                mreq.b = pmsm_pkg::mul_op_t'(flux_reg);
            end
            OP_BEMF:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(emf_reg[k_reg]);
                mreq.b = pmsm_pkg::mul_op_t'(w);
            end
            OP_RDROP:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(cur_reg[k_reg]);
                mreq.b = pmsm_pkg::mul_op_t'(res_reg);
            end
            OP_SLOPE:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(tmp_reg);
                mreq.b = pmsm_pkg::mul_op_t'(invl_reg);
            end
            OP_CURR:
            begin
                mreq.a = pmsm_pkg::mul_op_t'($signed(tmp_reg[31:0]))
                       + pmsm_pkg::mul_op_t'(slope_prev_reg[k_reg]);
                mreq.b = pmsm_pkg::mul_op_t'(ts_reg);
            end
            OP_DOT:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(cur_reg[k_reg]);
                mreq.b = pmsm_pkg::mul_op_t'(emf_reg[k_reg]);
            end
            OP_ACCEL:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(diff);
                mreq.b = pmsm_pkg::mul_op_t'(invj_reg);
            end
            OP_SPEED:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(acc_reg) + pmsm_pkg::mul_op_t'(accel_prev_reg);
                mreq.b = pmsm_pkg::mul_op_t'(ts_reg);
            end
            OP_POS:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(speed_reg) + pmsm_pkg::mul_op_t'(speed_prev_reg);
                mreq.b = pmsm_pkg::mul_op_t'(ts_reg);
            end
            OP_PH_LO:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(pos_reg[23:0]);
                mreq.b = pmsm_pkg::mul_op_t'(pp_reg);
            end
            OP_PH_HI:
            begin
                mreq.a = pmsm_pkg::mul_op_t'($signed(pos_reg[47:24]));
                mreq.b = pmsm_pkg::mul_op_t'(pp_reg);
            end
            OP_ANG_HI:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(x_reg[55:28]);
                mreq.b = pmsm_pkg::mul_op_t'(pmsm_pkg::TURNS_PER_RAD_Q32);
            end
            default:
            begin
                mreq.a = pmsm_pkg::mul_op_t'(x_reg[27:0]);
                mreq.b = pmsm_pkg::mul_op_t'(pmsm_pkg::TURNS_PER_RAD_Q32);
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            ts_reg   <= 32'd42950;
            pp_reg   <= 6'd4;
            flux_reg <= 31'd6554;
            res_reg  <= 31'd65536;
            invl_reg <= 31'd65536000;
            invj_reg <= 31'd65536000;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                pmsm_pkg::CFG_MODE:      mode_reg <= cfg_wdata[0];
                pmsm_pkg::CFG_TIME_STEP: ts_reg   <= cfg_wdata;
                pmsm_pkg::CFG_POLES:     pp_reg   <= cfg_wdata[5:0];
                pmsm_pkg::CFG_FLUX:      flux_reg <= cfg_wdata[30:0];
                pmsm_pkg::CFG_RES:       res_reg  <= cfg_wdata[30:0];
                pmsm_pkg::CFG_INV_L:     invl_reg <= cfg_wdata[30:0];
                pmsm_pkg::CFG_INV_J:     invj_reg <= cfg_wdata[30:0];
                default:                 ;
            endcase
        end
    end

    // Sequencer, state updates and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i]        <= '0;
                slope_prev_reg[i] <= '0;
                emf_reg[i]        <= '0;
            end
            speed_reg      <= '0;
            accel_prev_reg <= '0;
            speed_prev_reg <= '0;
            pos_reg        <= '0;
            phase_reg      <= '0;
            in_reg         <= '0;
            tmp_reg        <= '0;
            dot_reg        <= '0;
            torque_reg     <= '0;
            acc_reg        <= '0;
            x_reg          <= '0;
            st_reg         <= ST_IDLE;
            op_reg         <= OP_SIN_PP;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            // Raise the beat when a result is posted, drop it once taken
            if (post_res)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (st_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        in_reg  <= item.data;
                        k_reg   <= '0;
                        op_reg  <= OP_SIN_PP;
                        dot_reg <= '0;
                        st_reg  <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    st_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    st_reg <= ST_MUL;
                    op_reg <= op_reg + 4'd1;
                    case (op_reg)
                        OP_SIN_PP:
                            tmp_reg <= pmsm_pkg::tmp_t'(prod);
                        OP_EMF:
                            emf_reg[k_reg] <= pmsm_pkg::sat32(pmsm_pkg::wide_t'(prod_sh));
                        OP_BEMF:
                            tmp_reg <= prod_sh;
                        OP_RDROP:
                            tmp_reg <= pmsm_pkg::tmp_t'(pmsm_pkg::sat32(
                                pmsm_pkg::wide_t'(tmp_reg) + pmsm_pkg::wide_t'(volt_k)
                                - pmsm_pkg::wide_t'(prod_sh)));
                        OP_SLOPE:
                            tmp_reg <= pmsm_pkg::tmp_t'(pmsm_pkg::sat32(
                                pmsm_pkg::wide_t'(prod_sh)));
                        OP_CURR:
                        begin
                            cur_reg[k_reg] <= pmsm_pkg::sat32(pmsm_pkg::wide_t'(cur_reg[k_reg])
                                + pmsm_pkg::wide_t'(pmsm_pkg::trunc_shr(prod,
                                                     pmsm_pkg::TRAP_SHIFT)));
                            slope_prev_reg[k_reg] <= $signed(tmp_reg[31:0]);
                            if (k_reg == 2'd2)
                            begin
                                k_reg  <= '0;
                                op_reg <= OP_DOT;
                            end
                            else
                            begin
                                k_reg  <= k_reg + 2'd1;
                                op_reg <= OP_SIN_PP;
                            end
                        end
                        OP_DOT:
                        begin
                            dot_reg <= dot_sum;
                            if (k_reg == 2'd2)
                            begin
                                k_reg      <= '0;
                                torque_reg <= pmsm_pkg::sat32(-pmsm_pkg::wide_t'(dot_sum));
                                if (mode_reg)
                                begin
                                    speed_reg <= in_reg.forced_speed;
                                    acc_reg   <= '0;
                                    op_reg    <= OP_POS;
                                end
                            end
                            else
                            begin
                                k_reg  <= k_reg + 2'd1;
                                op_reg <= OP_DOT;
                            end
                        end
                        OP_ACCEL:
                            acc_reg <= pmsm_pkg::sat32(pmsm_pkg::wide_t'(prod_sh));
                        OP_SPEED:
                        begin
                            speed_reg <= pmsm_pkg::sat32(pmsm_pkg::wide_t'(speed_reg)
                                + pmsm_pkg::wide_t'(pmsm_pkg::trunc_shr(prod,
                                                     pmsm_pkg::TRAP_SHIFT)));
                            accel_prev_reg <= acc_reg;
                        end
                        OP_POS:
                        begin
                            pos_reg <= pmsm_pkg::sat48(pmsm_pkg::wide_t'(pos_reg)
                                + pmsm_pkg::wide_t'(pmsm_pkg::trunc_shr(prod,
                                                     pmsm_pkg::POS_SHIFT)));
                            speed_prev_reg <= speed_reg;
                        end
                        OP_PH_LO:
                            x_reg <= prod[55:0];
                        OP_PH_HI:
                            x_reg <= x_reg + {prod[31:0], 24'b0};
                        OP_ANG_HI:
                            tmp_reg <= $signed(pmsm_pkg::TMP_W'(prod[27:0]));
                        OP_ANG_LO:
                        begin
                            phase_reg <= ang_sum[55:24];
                            st_reg    <= ST_DONE;
                        end
                        default:
                            st_reg <= ST_IDLE;
                    endcase
                end
                default:
                begin
                    // Post the result once the output register is free
                    if (post_res)
                    begin
                        out_reg.motor_torque              <= torque_reg;
                        out_reg.current_a                 <= cur_reg[0];
                        out_reg.current_b                 <= cur_reg[1];
                        out_reg.current_c                 <= cur_reg[2];
                        out_reg.rotor_speed               <= speed_reg;
                        out_reg.rotor_acceleration        <= acc_reg;
                        out_reg.rotor_position            <= pos_reg;
                        st_reg                            <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign item.ready   = (st_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

/* hw/rtl/pmsm_mul.sv */
// Shared signed multiplier with a registered product.
module pmsm_mul (
    input  logic                clk,
    input  pmsm_pkg::mul_req_t  req,
    output pmsm_pkg::prod_t     prod
);

    pmsm_pkg::prod_t prod_reg;
    pmsm_pkg::prod_t prod_next;

    // Form the full-width product
    assign prod_next = $signed(req.a) * $signed(req.b);

    // Capture on request
    always_ff @(posedge clk)
    begin
        if (req.en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/pmsm_chk.sv */
// Port-level checker for the PMSM model step core, bound to the top level.
module pmsm_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  pmsm_pkg::result_t   out_data
);

    // Hold the result beat until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Keep the payload still while stalled
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // Go busy right after an accepted item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while a tick is in progress");

    // No result beat may rise while a tick is still on its first multiply
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 !$rose(out_valid))
        else $error("result posted too early after accept");

endmodule

bind pmsm_motor_model_step_core pmsm_chk u_pmsm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
